// ----- src/epts_pkg.sv -----
// Package for the eased position trajectory stepper: request codes, modes,
// queue entry type and the half-cosine easing table. No dependencies.
`timescale 1ns / 1ps
package epts_pkg;

    localparam int EaseDepth = 1024;
    localparam int EaseIdxW = $clog2(EaseDepth);

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ZERO    = 3'd1,
        REQ_RITUAL  = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_GOTO    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_HOLDING  = 2'd1,
        MODE_MOVING   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_STEP    = 3'd0,
        CFG_HOLD    = 3'd1,
        CFG_MOVE    = 3'd2,
        CFG_CURVE   = 3'd3,
        CFG_EASE_EN = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CURVE_LINEAR   = 2'd0,
        CURVE_COSINE   = 2'd1,
        CURVE_QUAD_IN  = 2'd2,
        CURVE_QUAD_OUT = 2'd3
    } t_curve;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_TAB,
        ST_EASE,
        ST_MUL,
        ST_ROUND,
        ST_OUT1,
        ST_OUT2
    } t_state;

    // classified item handed from front to back
    typedef struct packed {
        t_req        req;
        logic        known;
        logic [7:0]  tick_ms;
        logic [31:0] enc;
        logic [31:0] goto_tgt;
    } t_item;

    // Q30 Taylor series of 1-cos x, returned as (1-cos x)/2 in Q16; elaboration-time only
    function automatic logic [31:0] cos_entry(input int unsigned i);
        logic [63:0] x, x2, term, sum;
        logic [63:0] pi_q30;
        int k;
        pi_q30 = 64'd3373259426;
        x = (pi_q30 * 64'(i)) / 64'(EaseDepth);
        x2 = (x * x) >> 30;
        term = x2 >> 1;
        sum = term;
        for (k = 2; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum = sum + term;
            else sum = sum - term;
        end
        return 32'((sum + 64'd16384) >> 15);
    endfunction

    function automatic logic [16:0] ease_rom(input logic [EaseIdxW:0] i);
        logic [31:0] v;
        if (2 * int'(i) <= EaseDepth) v = cos_entry(int'(i));
        else v = 32'd65536 - cos_entry(EaseDepth - int'(i));
        return v[16:0];
    endfunction

endpackage

// ----- src/epts_front.sv -----
// Front part: accepts request items, classifies them and fills a two-entry queue.
// Depends on epts_pkg.
`timescale 1ns / 1ps
module epts_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_req_type,
    input  logic [7:0]           i_tick_ms,
    input  logic signed [31:0]   i_encoder_counts,
    input  logic signed [23:0]   i_goto_angle,
    output logic                 o_q_valid,
    output epts_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);
    epts_pkg::t_item r_mem [2];
    logic r_wr, r_rd;
    logic [1:0] r_cnt;
    epts_pkg::t_item n_item;
    logic push;

    always_comb begin
        n_item.req      = epts_pkg::t_req'(i_req_type);
        n_item.known    = (i_req_type <= 3'(epts_pkg::REQ_GOTO));
        n_item.tick_ms  = i_tick_ms;
        n_item.enc      = i_encoder_counts;
        n_item.goto_tgt = {{8{i_goto_angle[23]}}, i_goto_angle};
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= n_item;
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

// ----- src/epts_back.sv -----
// Back part: mode state, progress division, easing and result output register.
// Depends on epts_pkg.
`timescale 1ns / 1ps
module epts_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  epts_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    input  logic [15:0]          i_step_size,
    input  logic [15:0]          i_hold_time,
    input  logic [15:0]          i_move_time,
    input  logic [1:0]           i_easing_curve,
    input  logic                 i_easing_enable,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_target_valid,
    output logic signed [31:0]   o_target_counts,
    output logic                 o_output_enable,
    output logic [1:0]           o_machine_state,
    output logic                 o_ritual_on,
    output logic                 o_refused,
    output logic                 o_last
);
    localparam int IW = epts_pkg::EaseIdxW;

    epts_pkg::t_state r_st, n_st;
    epts_pkg::t_mode  r_mode, n_mode;
    logic r_zv, n_zv, r_rit, n_rit, r_ref, n_ref;
    logic [31:0] r_zoff, n_zoff, r_lt, n_lt, r_ms, n_ms, r_me, n_me;
    logic [15:0] r_mel, n_mel, r_hel, n_hel;
    logic [1:0]  r_nwr, n_nwr;
    logic [31:0] r_w0, n_w0, r_w1, n_w1;
    // divider
    logic [32:0] r_rem, n_rem;
    logic [16:0] r_q, n_q;
    logic [5:0]  r_cnt, n_cnt;
    logic [16:0] r_e, n_e;
    logic signed [49:0] r_prod, n_prod;
    // output register
    logic r_ov, n_ov, r_otv, n_otv, r_olast, n_olast;
    logic [31:0] r_otc, n_otc;
    logic r_ooe, n_ooe, r_orit, n_orit, r_oref, n_oref;
    epts_pkg::t_mode r_ost, n_ost;
    // half-cosine table, read at two registered addresses
    logic [16:0] ease_tab [epts_pkg::EaseDepth + 1];
    logic [16:0] r_e0, r_e1;

    logic [31:0] hold_sum, move_sum;
    logic [15:0] hold_sat, move_sat;
    logic [33:0] trial;
    logic [16:0] rq;
    logic [IW+16:0] pos;
    logic [IW:0] idx, idx1;
    logic [15:0] frac;
    logic signed [34:0] ediff;
    logic [33:0] qsq;
    logic signed [32:0] dlt;
    logic signed [49:0] sq;
    logic signed [31:0] sp;
    logic out_free;

    for (genvar g = 0; g <= epts_pkg::EaseDepth; g++) begin : g_tab
        assign ease_tab[g] = epts_pkg::ease_rom((IW + 1)'(g));
    end

    always_comb begin
        hold_sum = 32'(r_hel) + 32'(i_q_item.tick_ms);
        hold_sat = hold_sum > 32'd65535 ? 16'hFFFF : hold_sum[15:0];
        move_sum = 32'(r_mel) + 32'(i_q_item.tick_ms);
        move_sat = move_sum > 32'd65535 ? 16'hFFFF : move_sum[15:0];
        trial = {1'b0, r_rem} - {18'd0, i_move_time};
        rq = 17'h10000 - r_q;
        pos = (IW + 17)'(r_q) << IW;
        idx = pos[IW+16:16];
        idx1 = (idx >= (IW + 1)'(epts_pkg::EaseDepth)) ? idx : idx + 1'b1;
        frac = pos[15:0];
        ediff = 35'(signed'({1'b0, r_e1})) - 35'(signed'({1'b0, r_e0}));
        ediff = ediff * signed'({1'b0, frac});
        qsq = (i_easing_curve == epts_pkg::CURVE_QUAD_IN) ? 34'(r_q) * 34'(r_q)
                                                          : 34'(rq) * 34'(rq);
        dlt = 33'(signed'(r_me)) - 33'(signed'(r_ms));
        sq = r_prod >>> 16;
        if (r_prod < 0 && r_prod[15:0] != 16'd0) sq = sq + 50'sd1;
        sp = 32'(sq) + r_ms;
    end

    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        r_e0 <= ease_tab[idx];
        r_e1 <= ease_tab[idx1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= epts_pkg::ST_IDLE;
            r_mode <= epts_pkg::MODE_RELEASED;
            r_zv <= 1'b0; r_rit <= 1'b0;
            r_zoff <= '0; r_lt <= '0; r_ms <= '0; r_me <= '0;
            r_mel <= '0; r_hel <= '0;
            r_ov <= 1'b0;
            r_ooe <= 1'b0; r_ost <= epts_pkg::MODE_RELEASED;
            r_orit <= 1'b0; r_oref <= 1'b0;
        end else begin
            r_st <= n_st; r_mode <= n_mode;
            r_zv <= n_zv; r_rit <= n_rit;
            r_zoff <= n_zoff; r_lt <= n_lt; r_ms <= n_ms; r_me <= n_me;
            r_mel <= n_mel; r_hel <= n_hel;
            r_ov <= n_ov;
            r_ooe <= n_ooe; r_ost <= n_ost;
            r_orit <= n_orit; r_oref <= n_oref;
        end
        r_ref <= n_ref; r_nwr <= n_nwr; r_w0 <= n_w0; r_w1 <= n_w1;
        r_rem <= n_rem; r_q <= n_q; r_cnt <= n_cnt; r_e <= n_e; r_prod <= n_prod;
        r_otv <= n_otv; r_olast <= n_olast; r_otc <= n_otc;
    end

    always_comb begin
        n_st = r_st; n_mode = r_mode; n_zv = r_zv; n_rit = r_rit;
        n_zoff = r_zoff; n_lt = r_lt; n_ms = r_ms; n_me = r_me;
        n_mel = r_mel; n_hel = r_hel; n_ref = r_ref; n_nwr = r_nwr;
        n_w0 = r_w0; n_w1 = r_w1; n_rem = r_rem; n_q = r_q; n_cnt = r_cnt;
        n_e = r_e; n_prod = r_prod;
        n_ov = r_ov && i_stall; n_otv = r_otv; n_olast = r_olast; n_otc = r_otc;
        n_ooe = r_ooe; n_ost = r_ost; n_orit = r_orit; n_oref = r_oref;
        o_q_pop = 1'b0;
        unique case (r_st)
            epts_pkg::ST_IDLE: begin
                if (i_q_valid) n_st = epts_pkg::ST_EXEC;
            end
            epts_pkg::ST_EXEC: begin
                n_ref = 1'b0; n_nwr = 2'd0;
                n_st = epts_pkg::ST_OUT1;
                if (!i_q_item.known) begin
                end else begin
                    unique case (i_q_item.req)
                        epts_pkg::REQ_TICK: begin
                            if (r_mode == epts_pkg::MODE_MOVING) begin
                                n_mel = move_sat;
                                if (move_sat >= i_move_time) begin
                                    n_lt = r_me; n_w0 = r_zoff + r_me; n_nwr = 2'd1;
                                    n_mode = epts_pkg::MODE_HOLDING; n_hel = '0;
                                end else if (i_easing_enable) begin
                                    n_rem = 33'(move_sat); n_q = '0; n_cnt = 6'd17;
                                    n_st = epts_pkg::ST_DIV;
                                end else begin
                                    n_w0 = r_zoff + r_me; n_nwr = 2'd1;
                                end
                            end else if (r_mode == epts_pkg::MODE_HOLDING) begin
                                n_hel = hold_sat;
                                n_w0 = r_zoff + r_lt; n_nwr = 2'd1;
                                if (r_rit && hold_sat >= i_hold_time) begin
                                    n_ms = r_lt; n_me = r_lt + 32'(i_step_size);
                                    n_mel = '0; n_mode = epts_pkg::MODE_MOVING;
                                    if (!i_easing_enable) begin
                                        n_w1 = r_zoff + r_lt + 32'(i_step_size);
                                        n_nwr = 2'd2;
                                    end
                                end
                            end
                        end
                        epts_pkg::REQ_ZERO: begin
                            n_zoff = i_q_item.enc; n_zv = 1'b1; n_lt = '0;
                            n_mode = epts_pkg::MODE_HOLDING; n_rit = 1'b0; n_hel = '0;
                            n_w0 = i_q_item.enc; n_nwr = 2'd1;
                        end
                        epts_pkg::REQ_RITUAL: begin
                            if (!r_zv) n_ref = 1'b1;
                            else begin
                                n_rit = 1'b1;
                                if (r_mode == epts_pkg::MODE_HOLDING) begin
                                    n_ms = r_lt; n_me = r_lt + 32'(i_step_size);
                                    n_mel = '0; n_mode = epts_pkg::MODE_MOVING;
                                    if (!i_easing_enable) begin
                                        n_w0 = r_zoff + r_lt + 32'(i_step_size);
                                        n_nwr = 2'd1;
                                    end
                                end
                            end
                        end
                        epts_pkg::REQ_RELEASE: begin
                            n_mode = epts_pkg::MODE_RELEASED; n_zv = 1'b0;
                            n_rit = 1'b0; n_lt = '0;
                        end
                        epts_pkg::REQ_GOTO: begin
                            if (!r_zv) n_ref = 1'b1;
                            else begin
                                n_rit = 1'b0;
                                n_ms = r_lt; n_me = i_q_item.goto_tgt;
                                n_mel = '0; n_mode = epts_pkg::MODE_MOVING;
                                if (!i_easing_enable) begin
                                    n_w0 = r_zoff + i_q_item.goto_tgt; n_nwr = 2'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            epts_pkg::ST_DIV: begin
                // restoring division, one quotient bit a cycle
                if (!trial[33]) begin
                    n_rem = trial[32:0] << 1; n_q = {r_q[15:0], 1'b1};
                end else begin
                    n_rem = r_rem << 1; n_q = {r_q[15:0], 1'b0};
                end
                if (r_cnt == 6'd17) begin
                    n_rem = r_rem << 1; n_q = '0;
                    n_rem = 33'(r_mel) << 1;
                    n_q = '0;
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) n_st = epts_pkg::ST_TAB;
            end
            epts_pkg::ST_TAB: begin
                n_st = epts_pkg::ST_EASE;
            end
            epts_pkg::ST_EASE: begin
                case (i_easing_curve)
                    epts_pkg::CURVE_LINEAR: n_e = r_q;
                    epts_pkg::CURVE_COSINE: begin
                        if (idx >= (IW + 1)'(epts_pkg::EaseDepth)) n_e = r_e0;
                        else n_e = 17'(35'(signed'({1'b0, r_e0})) + (ediff >>> 16)
                                 + ((ediff < 0 && ediff[15:0] != 16'd0) ? 35'sd1 : 35'sd0));
                    end
                    epts_pkg::CURVE_QUAD_IN: n_e = 17'(qsq >> 16);
                    default: n_e = 17'h10000 - 17'(qsq >> 16);
                endcase
                n_st = epts_pkg::ST_MUL;
            end
            epts_pkg::ST_MUL: begin
                n_prod = 50'(dlt) * 50'(signed'({1'b0, r_e}));
                n_st = epts_pkg::ST_ROUND;
            end
            epts_pkg::ST_ROUND: begin
                n_w0 = r_zoff + sp; n_nwr = 2'd1;
                n_st = epts_pkg::ST_OUT1;
            end
            epts_pkg::ST_OUT1: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_otv = (r_nwr != 2'd0);
                    n_otc = (r_nwr != 2'd0) ? r_w0 : '0;
                    n_olast = (r_nwr != 2'd2);
                    n_ooe = (r_mode != epts_pkg::MODE_RELEASED);
                    n_ost = r_mode; n_orit = r_rit; n_oref = r_ref;
                    if (r_nwr == 2'd2) n_st = epts_pkg::ST_OUT2;
                    else begin
                        n_st = epts_pkg::ST_IDLE; o_q_pop = 1'b1;
                    end
                end
            end
            epts_pkg::ST_OUT2: begin
                if (out_free) begin
                    n_ov = 1'b1; n_otv = 1'b1; n_otc = r_w1; n_olast = 1'b1;
                    n_ooe = (r_mode != epts_pkg::MODE_RELEASED);
                    n_ost = r_mode; n_orit = r_rit; n_oref = r_ref;
                    n_st = epts_pkg::ST_IDLE; o_q_pop = 1'b1;
                end
            end
            default: n_st = epts_pkg::ST_IDLE;
        endcase
    end

    assign o_valid         = r_ov;
    assign o_target_valid  = r_otv;
    assign o_target_counts = r_otc;
    assign o_output_enable = r_ooe;
    assign o_machine_state = r_ost;
    assign o_ritual_on     = r_orit;
    assign o_refused       = r_oref;
    assign o_last          = r_olast;
endmodule

// ----- src/eased_position_trajectory_stepper.sv -----
// Top level of the eased position trajectory stepper.
// Depends on epts_pkg, epts_front and epts_back.
`timescale 1ns / 1ps
// A request item passes the back end through the states IDLE, EXEC and OUT1
// (and OUT2 when it gives two results); a moving tick that computes an eased
// setpoint goes from EXEC through the progress divider (one load, 16 quotient
// bits), then the table read, easing, multiply and rounding states. A stalled
// result holds the back end in its output state until it is taken. A two-item
// queue lets requests be taken while the back end works. Status fields are the
// mode after the item and travel with each result.
module eased_position_trajectory_stepper (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_req_type,
    input  logic [7:0]           i_tick_ms,
    input  logic signed [31:0]   i_encoder_counts,
    input  logic signed [23:0]   i_goto_angle,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_target_valid,
    output logic signed [31:0]   o_target_counts,
    output logic                 o_output_enable,
    output logic [1:0]           o_machine_state,
    output logic                 o_ritual_on,
    output logic                 o_refused,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    logic [15:0] r_step, r_hold, r_move;
    logic [1:0]  r_curve;
    logic        r_ease_en;
    logic q_valid, q_pop;
    epts_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 16'd4500; r_hold <= 16'd2000; r_move <= 16'd1500;
            r_curve <= epts_pkg::CURVE_COSINE; r_ease_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (epts_pkg::t_cfg_idx'(i_cfg_index))
                epts_pkg::CFG_STEP:    r_step <= i_cfg_data;
                epts_pkg::CFG_HOLD:    r_hold <= i_cfg_data;
                epts_pkg::CFG_MOVE:    r_move <= i_cfg_data;
                epts_pkg::CFG_CURVE:   r_curve <= i_cfg_data[1:0];
                epts_pkg::CFG_EASE_EN: r_ease_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    epts_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_tick_ms,
        .i_encoder_counts, .i_goto_angle,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    epts_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_step_size(r_step), .i_hold_time(r_hold), .i_move_time(r_move),
        .i_easing_curve(r_curve), .i_easing_enable(r_ease_en),
        .o_valid, .i_stall, .o_target_valid, .o_target_counts, .o_output_enable,
        .o_machine_state, .o_ritual_on, .o_refused, .o_last
    );

    a_no_target_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_target_valid |-> o_target_counts == 32'd0)
        else $error("target counts set without a target");
    a_refused_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_refused |-> !o_target_valid)
        else $error("refused item wrote a target");
    a_released_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_output_enable == (o_machine_state != epts_pkg::MODE_RELEASED))
        else $error("drive enable disagrees with mode");
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for eased_position_trajectory_stepper: directed table,
// then random phases across register settings. Depends on epts_pkg and the top.
`timescale 1ns / 1ps
module tb;

    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        tv;
        logic [31:0] tc;
        logic        oe;
        logic [1:0]  st;
        logic        armed;
        logic        rf;
        logic        last;
    } t_target_res;

    typedef struct {
        logic [2:0]  req;
        logic [7:0]  ms;
        logic [31:0] enc;
        logic [23:0] ga;
        bit          chk;
        bit          tv;
        logic [31:0] tc;
        logic [1:0]  st;
        bit          rf;
    } t_row;

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic [2:0]  i_req_type = 0;
    logic [7:0]  i_tick_ms = 0;
    logic signed [31:0] i_encoder_counts = 0;
    logic signed [23:0] i_goto_angle = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic        o_stall, o_valid, o_target_valid, o_output_enable;
    logic signed [31:0] o_target_counts;
    logic [1:0]  o_machine_state;
    logic        o_ritual_on, o_refused, o_last;

    eased_position_trajectory_stepper u_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // predictor state
    bit [31:0] cfg_step = 4500, cfg_hold = 2000, cfg_move = 1500;
    bit [1:0]  cfg_curve = 1;
    bit        cfg_ease = 1;
    epts_pkg::t_mode mode = epts_pkg::MODE_RELEASED;
    bit        zeroed = 0, armed = 0;
    bit [31:0] zero_off = 0, logical = 0, mv_from = 0, mv_to = 0;
    bit [31:0] mv_ms = 0, hold_ms = 0;
    bit [16:0] half_cos [0:1024];
    bit [31:0] wr_buf [2];
    int        wr_n;

    t_target_res pending_targets [$];
    t_row        typed_checks [$];
    int errors = 0, accepted = 0, cycles = 0, burst_left = 0;
    bit held = 0;

    t_row dir_tab [26] = '{
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0},
        '{epts_pkg::REQ_RITUAL, 0, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 1},
        '{epts_pkg::REQ_GOTO, 0, 0, 24'h7FFFFF, 1, 0, 0, epts_pkg::MODE_RELEASED, 1},
        '{REQ_SPARE_HI, 0, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0},
        '{epts_pkg::REQ_ZERO, 0, 32'h7FFFFFFF, 0, 1, 1, 32'h7FFFFFFF,
          epts_pkg::MODE_HOLDING, 0},
        '{epts_pkg::REQ_TICK, 0, 0, 0, 1, 1, 32'h7FFFFFFF, epts_pkg::MODE_HOLDING, 0},
        '{epts_pkg::REQ_GOTO, 0, 0, 24'h7FFFFF, 1, 0, 0, epts_pkg::MODE_MOVING, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_RITUAL, 0, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_RITUAL, 0, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd1, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd128, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_ZERO, 0, 32'h80000000, 0, 1, 1, 32'h80000000,
          epts_pkg::MODE_HOLDING, 0},
        '{epts_pkg::REQ_GOTO, 0, 0, 24'h800000, 1, 0, 0, epts_pkg::MODE_MOVING, 0},
        '{epts_pkg::REQ_TICK, 8'd100, 0, 0, 0, 0, 0, 0, 0},
        '{epts_pkg::REQ_RELEASE, 0, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0},
        '{epts_pkg::REQ_TICK, 8'd255, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0},
        '{REQ_SPARE_LO, 0, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0},
        '{epts_pkg::REQ_ZERO, 0, 0, 0, 1, 1, 0, epts_pkg::MODE_HOLDING, 0},
        '{epts_pkg::REQ_RELEASE, 0, 0, 0, 1, 0, 0, epts_pkg::MODE_RELEASED, 0}
    };

    // settings per phase: step, hold, move, curve, easing enable
    int phase_cfg [7][5] = '{
        '{1, 0, 50, 0, 1},
        '{36000, 60000, 60000, 2, 1},
        '{4500, 300, 1000, 3, 1},
        '{100, 0, 0, 1, 1},
        '{2000, 500, 800, 1, 0},
        '{36000, 0, 50, 2, 0},
        '{777, 1000, 1500, 1, 1}
    };

    function automatic bit [16:0] cos_q16(int unsigned i);
        bit [63:0] x, x2, term, acc;
        int k;
        x = (64'd3373259426 * 64'(i)) / 64'd1024;
        x2 = (x * x) >> 30;
        term = x2 >> 1;
        acc = term;
        for (k = 2; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc + term;
            else acc = acc - term;
        end
        return 17'((acc + 64'd16384) >> 15);
    endfunction

    function automatic longint eased_progress(longint q);
        longint pos, frac, idx, r;
        case (cfg_curve)
            epts_pkg::CURVE_LINEAR: return q;
            epts_pkg::CURVE_QUAD_IN: return (q * q) >>> 16;
            epts_pkg::CURVE_QUAD_OUT: begin
                r = 65536 - q;
                return 65536 - ((r * r) >>> 16);
            end
            default: begin
                pos = q * 1024;
                idx = pos >>> 16;
                frac = pos & 64'hFFFF;
                if (idx >= 1024) return longint'(half_cos[1024]);
                return longint'(half_cos[idx]) +
                    (longint'(half_cos[idx + 1]) - longint'(half_cos[idx])) * frac / 65536;
            end
        endcase
    endfunction

    function automatic bit [31:0] sat_ms(bit [31:0] a, bit [31:0] b);
        return (a + b > 65535) ? 32'd65535 : a + b;
    endfunction

    task automatic emit_target(bit [31:0] sp);
        if (wr_n < 2) begin
            wr_buf[wr_n] = zero_off + sp;
            wr_n++;
        end
    endtask

    task automatic begin_move(bit [31:0] to);
        mv_from = logical;
        mv_to = to;
        mv_ms = 0;
        mode = epts_pkg::MODE_MOVING;
        if (!cfg_ease) emit_target(mv_to);
    endtask

    task automatic setpoint_step(logic [2:0] req, logic [7:0] ms, logic [31:0] enc,
                                 logic [23:0] ga);
        bit rf;
        int n;
        longint q, a, d;
        bit [63:0] sp;
        t_target_res r;
        rf = 0;
        wr_n = 0;
        case (req)
            epts_pkg::REQ_TICK: begin
                if (mode == epts_pkg::MODE_MOVING) begin
                    mv_ms = sat_ms(mv_ms, ms);
                    if (mv_ms >= cfg_move) begin
                        logical = mv_to;
                        emit_target(logical);
                        mode = epts_pkg::MODE_HOLDING;
                        hold_ms = 0;
                    end else if (cfg_ease) begin
                        q = (longint'(mv_ms) << 16) / longint'(cfg_move);
                        a = longint'(signed'(mv_from));
                        d = longint'(signed'(mv_to)) - a;
                        sp = a + d * eased_progress(q) / 65536;
                        emit_target(sp[31:0]);
                    end else begin
                        emit_target(mv_to);
                    end
                end else if (mode == epts_pkg::MODE_HOLDING) begin
                    hold_ms = sat_ms(hold_ms, ms);
                    emit_target(logical);
                    if (armed && hold_ms >= cfg_hold) begin_move(logical + cfg_step);
                end
            end
            epts_pkg::REQ_ZERO: begin
                zero_off = enc;
                zeroed = 1;
                logical = 0;
                mode = epts_pkg::MODE_HOLDING;
                armed = 0;
                hold_ms = 0;
                emit_target(0);
            end
            epts_pkg::REQ_RITUAL: begin
                if (!zeroed) rf = 1;
                else begin
                    armed = 1;
                    if (mode == epts_pkg::MODE_HOLDING) begin_move(logical + cfg_step);
                end
            end
            epts_pkg::REQ_RELEASE: begin
                mode = epts_pkg::MODE_RELEASED;
                zeroed = 0;
                armed = 0;
                logical = 0;
            end
            epts_pkg::REQ_GOTO: begin
                if (!zeroed) rf = 1;
                else begin
                    armed = 0;
                    begin_move({{8{ga[23]}}, ga});
                end
            end
            default: ;
        endcase
        n = wr_n ? wr_n : 1;
        for (int k = 0; k < n; k++) begin
            r.tv = k < wr_n;
            r.tc = (k < wr_n) ? wr_buf[k] : 32'd0;
            r.oe = mode != epts_pkg::MODE_RELEASED;
            r.st = mode;
            r.armed = armed;
            r.rf = rf;
            r.last = k == n - 1;
            pending_targets.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // take items at acceptance and queue their targets
    always @(posedge i_clk) begin
        t_row row;
        int first_idx;
        if (i_rst_n && i_valid && !o_stall) begin
            accepted++;
            first_idx = pending_targets.size();
            setpoint_step(i_req_type, i_tick_ms, i_encoder_counts, i_goto_angle);
            row = typed_checks.pop_front();
            if (row.chk) begin
                if (pending_targets[first_idx].tv != row.tv)
                    report_mismatch("typed target_valid", pending_targets[first_idx].tv,
                                    row.tv);
                if (pending_targets[first_idx].tc != row.tc)
                    report_mismatch("typed target_counts", pending_targets[first_idx].tc,
                                    row.tc);
                if (pending_targets[first_idx].st != row.st)
                    report_mismatch("typed machine_state", pending_targets[first_idx].st,
                                    row.st);
                if (pending_targets[first_idx].rf != row.rf)
                    report_mismatch("typed refused", pending_targets[first_idx].rf, row.rf);
            end
        end
    end

    always @(posedge i_clk) begin
        t_target_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_targets.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                e = pending_targets.pop_front();
                if (o_target_valid != e.tv) report_mismatch("target_valid", o_target_valid, e.tv);
                if (o_target_counts != e.tc)
                    report_mismatch("target_counts", o_target_counts, e.tc);
                if (o_output_enable != e.oe)
                    report_mismatch("output_enable", o_output_enable, e.oe);
                if (o_machine_state != e.st)
                    report_mismatch("machine_state", o_machine_state, e.st);
                if (o_ritual_on != e.armed) report_mismatch("ritual_on", o_ritual_on, e.armed);
                if (o_refused != e.rf) report_mismatch("refused", o_refused, e.rf);
                if (o_last != e.last) report_mismatch("last", o_last, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stall runs, free runs, and one long hold-off
    initial begin
        int len;
        forever begin
            if (!held && accepted >= 400) begin
                i_stall <= 1;
                repeat (400) @(posedge i_clk);
                held = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                i_stall <= 1;
                len = $urandom_range(1, 6);
                repeat (len) @(posedge i_clk);
            end else begin
                i_stall <= 0;
                len = $urandom_range(1, 25);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    task automatic offer(t_row row);
        int gap;
        if (burst_left == 0) begin
            i_valid <= 0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        typed_checks.push_back(row);
        i_valid <= 1;
        i_req_type <= row.req;
        i_tick_ms <= row.ms;
        i_encoder_counts <= row.enc;
        i_goto_angle <= row.ga;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(epts_pkg::t_cfg_idx idx, int val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val[15:0];
        case (idx)
            epts_pkg::CFG_STEP: cfg_step = val;
            epts_pkg::CFG_HOLD: cfg_hold = val;
            epts_pkg::CFG_MOVE: cfg_move = val;
            epts_pkg::CFG_CURVE: cfg_curve = val[1:0];
            default: cfg_ease = val[0];
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_row random_row();
        t_row row;
        int pick;
        row = '{default: 0};
        row.ms = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                             : 8'($urandom_range(0, 255));
        row.enc = $urandom;
        row.ga = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 80000) - 40000);
        pick = $urandom_range(0, 99);
        if (!zeroed && pick < 40) row.req = epts_pkg::REQ_ZERO;
        else if (pick < 62) row.req = epts_pkg::REQ_TICK;
        else if (pick < 70) row.req = epts_pkg::REQ_ZERO;
        else if (pick < 80) row.req = epts_pkg::REQ_RITUAL;
        else if (pick < 85) row.req = epts_pkg::REQ_RELEASE;
        else if (pick < 95) row.req = epts_pkg::REQ_GOTO;
        else row.req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        if (pick >= 40 && pick < 62 && $urandom_range(0, 1)) row.req = epts_pkg::REQ_TICK;
        return row;
    endfunction

    initial begin
        t_row row;
        for (int i = 0; i <= 1024; i++)
            half_cos[i] = (2 * i <= 1024) ? cos_q16(i) : 17'(65536 - cos_q16(1024 - i));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir_tab[i]) offer(dir_tab[i]);
        drain();
        for (int p = 0; p < 7; p++) begin
            cfg_write(epts_pkg::CFG_STEP, phase_cfg[p][0]);
            cfg_write(epts_pkg::CFG_HOLD, phase_cfg[p][1]);
            cfg_write(epts_pkg::CFG_MOVE, phase_cfg[p][2]);
            cfg_write(epts_pkg::CFG_CURVE, phase_cfg[p][3]);
            cfg_write(epts_pkg::CFG_EASE_EN, phase_cfg[p][4]);
            i_cfg_we <= 0;
            if (p == 1) begin
                // long hold so the hold timer saturates
                row = '{default: 0};
                row.req = epts_pkg::REQ_ZERO;
                offer(row);
                row.req = epts_pkg::REQ_TICK;
                row.ms = 8'd255;
                repeat (270) offer(row);
                row.req = epts_pkg::REQ_RITUAL;
                offer(row);
            end
            repeat (p == 1 ? 100 : 225) offer(random_row());
            drain();
        end
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

// ----- files.f -----
src/epts_pkg.sv
src/epts_front.sv
src/epts_back.sv
src/eased_position_trajectory_stepper.sv
bench/tb.sv
